### rtl/joystick_calibrate_normalize_assert.svh
// Assertion macros for the joystick calibrate/normalize block.
`ifndef JOYSTICK_CALIBRATE_NORMALIZE_ASSERT_SVH
`define JOYSTICK_CALIBRATE_NORMALIZE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define JCN_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("jcn assertion failed");

// Next-cycle implication, checked outside reset.
`define JCN_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("jcn assertion failed");

`endif

### rtl/jcn_pkg.sv
// Shared constants and types for the joystick calibrate/normalize block.
`timescale 1ns / 1ps
package jcn_pkg;
    localparam int NEUTRAL_SAMPLES = 20;
    localparam int EXTREME_SAMPLES = 200;
    localparam int DIV_STEPS       = 30;   // bits of |d| * 32768
    localparam int QDEPTH          = 2;

    // neutral average as a reciprocal multiply: floor(sum * RECIP >> SHIFT) equals
    // sum / NEUTRAL_SAMPLES for any 20-bit sum and any sample count up to 32
    localparam int         NEUTRAL_SHIFT = 25;
    localparam logic [25:0] NEUTRAL_RECIP =
        26'(((64'd1 << NEUTRAL_SHIFT) + 64'(NEUTRAL_SAMPLES) - 64'd1) / 64'(NEUTRAL_SAMPLES));

    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_NEUTRAL = 2'd1;
    localparam logic [1:0] MODE_EXTREME = 2'd2;

    typedef struct packed {
        logic               cal;     // calibrated path
        logic signed [15:0] d;       // raw - centre
        logic signed [15:0] span;    // half-span on the matching side
        logic signed [15:0] direct;  // uncalibrated result
    } t_axis;

    typedef struct packed {
        t_axis x;
        t_axis y;
        logic  pressed;
        logic  is_cal;
        logic  done;
    } t_item;
endpackage

### rtl/joystick_calibrate_normalize.sv
// Top level: joystick calibration and Q1.15 normalization.
//
//  channel   dir  width  contents (lowest bit first)
//  s_axis    in   40     x_word[15:0], y_word[31:16], button_level[32], zero pad
//  m_axis    out  40     x_norm[15:0], y_norm[31:16], pressed[32], is_calibrated[33],
//                        phase_done[34], zero pad
//  cfg       in   2      mode, written when i_cfg_we is high
//
//  Each beat passes through the back end in order: a load from the queue, the restoring
//  divider (both axes in parallel, one quotient bit per cycle), then a move into the
//  output register once that register is free. The divider sets the sustained rate.
//  The front end takes a beat whenever the 2-entry queue has room, so input and
//  output stall independently. Reset (i_rst_n low, synchronous) restores the
//  default centre, full-range bounds, mode normal and an empty queue.
`timescale 1ns / 1ps
`include "joystick_calibrate_normalize_assert.svh"
module joystick_calibrate_normalize import jcn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // x_word, y_word, button_level
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // x_norm, y_norm, pressed, is_calibrated, phase_done
);
    t_item push_item, pop_item;
    logic  push, pop, q_empty, q_full;
    logic [$clog2(QDEPTH+1)-1:0] q_count;

    // classify / capture
    jcn_front u_front (
        .i_clk, .i_rst_n,
        .i_cfg_we, .i_cfg_wdata,
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_data   (s_axis_tdata[32:0]),
        .i_q_full (q_full),
        .o_push   (push),
        .o_item   (push_item)
    );

    jcn_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_count (q_count)
    );

    // divide / saturate
    jcn_back u_back (
        .i_clk, .i_rst_n,
        .i_q_empty (q_empty),
        .i_item    (pop_item),
        .o_pop     (pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata)
    );

    `JCN_ASSERT_NOW(a_no_push_full, push, !q_full)
    `JCN_ASSERT_NEXT(a_push_lands, push, q_count != '0)
    `JCN_ASSERT_NOW(a_no_pop_empty, pop, !q_empty)
endmodule

### rtl/jcn_front.sv
// Front end: clamps samples, runs neutral/extreme capture and queues work for the divider.
`timescale 1ns / 1ps
module jcn_front import jcn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [32:0] i_data,
    input  logic        i_q_full,
    output logic        o_push,
    output t_item       o_item
);
    logic [1:0]  r_mode, n_mode;
    logic [14:0] r_cx, n_cx, r_cy, n_cy;
    logic [14:0] r_lox, n_lox, r_hix, n_hix, r_loy, n_loy, r_hiy, n_hiy;
    logic [14:0] r_tb [4];
    logic [14:0] n_tb [4];
    logic [19:0] r_sumx, n_sumx, r_sumy, n_sumy;
    logic [7:0]  r_cnt, n_cnt;
    logic        r_cal, n_cal;
    logic        done;
    logic [14:0] rx, ry;

    function automatic t_axis axis_calc(input logic [14:0] raw, input logic [14:0] c,
                                        input logic [14:0] lo, input logic [14:0] hi,
                                        input logic cal);
        t_axis a;
        a.cal    = cal;
        a.d      = $signed({1'b0, raw}) - $signed({1'b0, c});
        a.span   = (raw < c) ? $signed({1'b0, c}) - $signed({1'b0, lo})
                             : $signed({1'b0, hi}) - $signed({1'b0, c});
        a.direct = {raw, 1'b0} ^ 16'h8000;
        return a;
    endfunction

    // sum / NEUTRAL_SAMPLES, low 15 bits
    function automatic logic [14:0] neutral_avg(input logic [19:0] s);
        logic [45:0] p;
        p = {26'd0, s} * {20'd0, NEUTRAL_RECIP};
        return p[NEUTRAL_SHIFT+14:NEUTRAL_SHIFT];
    endfunction

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && o_ready;
    assign rx = i_data[15] ? 15'd0 : i_data[14:0];
    assign ry = i_data[31] ? 15'd0 : i_data[30:16];

    always_comb begin
        n_mode = r_mode; n_cx = r_cx; n_cy = r_cy;
        n_lox = r_lox; n_hix = r_hix; n_loy = r_loy; n_hiy = r_hiy;
        n_tb = r_tb; n_sumx = r_sumx; n_sumy = r_sumy; n_cnt = r_cnt; n_cal = r_cal;
        done = 1'b0;
        if (i_cfg_we) begin
            n_mode = i_cfg_wdata;
            n_cnt  = '0;
            n_sumx = '0;
            n_sumy = '0;
        end else if (o_push) begin
            unique case (r_mode)
                MODE_NEUTRAL: begin
                    n_sumx = r_sumx + {5'd0, rx};
                    n_sumy = r_sumy + {5'd0, ry};
                    n_cnt  = r_cnt + 8'd1;
                    if (n_cnt >= 8'(NEUTRAL_SAMPLES)) begin
                        n_cx   = neutral_avg(n_sumx);
                        n_cy   = neutral_avg(n_sumy);
                        n_sumx = '0;
                        n_sumy = '0;
                        n_cnt  = '0;
                        done   = 1'b1;
                    end
                end
                MODE_EXTREME: begin
                    if (r_cnt == 8'd0) begin
                        n_tb[0] = r_cx; n_tb[1] = r_cx;
                        n_tb[2] = r_cy; n_tb[3] = r_cy;
                    end
                    if (rx < n_tb[0]) n_tb[0] = rx;
                    if (rx > n_tb[1]) n_tb[1] = rx;
                    if (ry < n_tb[2]) n_tb[2] = ry;
                    if (ry > n_tb[3]) n_tb[3] = ry;
                    n_cnt = r_cnt + 8'd1;
                    if (n_cnt >= 8'(EXTREME_SAMPLES)) begin
                        n_lox = n_tb[0]; n_hix = n_tb[1];
                        n_loy = n_tb[2]; n_hiy = n_tb[3];
                        n_cal = 1'b1;
                        n_cnt = '0;
                        done  = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_item.x       = axis_calc(rx, n_cx, n_lox, n_hix, n_cal);
        o_item.y       = axis_calc(ry, n_cy, n_loy, n_hiy, n_cal);
        o_item.pressed = !i_data[32];
        o_item.is_cal  = n_cal;
        o_item.done    = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_cx <= 15'd16384; r_cy <= 15'd16384;
            r_lox <= '0; r_hix <= 15'd32767; r_loy <= '0; r_hiy <= 15'd32767;
            r_tb <= '{default: '0};
            r_sumx <= '0; r_sumy <= '0; r_cnt <= '0; r_cal <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_cx <= n_cx; r_cy <= n_cy;
            r_lox <= n_lox; r_hix <= n_hix; r_loy <= n_loy; r_hiy <= n_hiy;
            r_tb <= n_tb;
            r_sumx <= n_sumx; r_sumy <= n_sumy; r_cnt <= n_cnt; r_cal <= n_cal;
        end
    end
endmodule

### rtl/jcn_fifo.sv
// Two-entry queue between the front end and the divider.
`timescale 1ns / 1ps
module jcn_fifo import jcn_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty,
    output logic  o_full,
    output logic [$clog2(QDEPTH+1)-1:0] o_count
);
    localparam int PW = $clog2(QDEPTH);
    t_item r_mem [QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [$clog2(QDEPTH+1)-1:0] r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == ($clog2(QDEPTH+1))'(QDEPTH));
    assign o_item  = r_mem[r_rp];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_count <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == PW'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == PW'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            if (i_push && !i_pop) r_count <= r_count + 1'b1;
            else if (i_pop && !i_push) r_count <= r_count - 1'b1;
        end
    end
endmodule

### rtl/jcn_back.sv
// Back end: bit-serial restoring divide for both axes, saturation, output register.
`timescale 1ns / 1ps
module jcn_back import jcn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [39:0] o_tdata
);
    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_HOLD} t_state;
    localparam int CW = $clog2(DIV_STEPS + 1);

    t_state r_state;
    t_item  r_item;
    logic [CW-1:0]          r_step;
    logic [DIV_STEPS-1:0]   r_num [2];
    logic [DIV_STEPS-1:0]   r_q   [2];
    logic [15:0]            r_rem [2];
    logic [14:0]            r_div [2];
    logic                   r_neg [2];
    logic                   r_tvalid;
    logic [39:0]            r_tdata;

    logic [15:0] trial [2];
    t_axis       ax    [2];
    logic [15:0] res   [2];

    function automatic logic [14:0] mag15(input logic signed [15:0] v);
        logic [15:0] m;
        m = v[15] ? 16'(-v) : 16'(v);
        return m[14:0];
    endfunction

    function automatic logic [15:0] finish(input t_axis a, input logic neg,
                                           input logic [DIV_STEPS-1:0] q);
        logic [15:0] r;
        if (!a.cal) r = a.direct;
        else if (a.span == '0) r = '0;
        else if (!neg) r = (q > DIV_STEPS'(32767)) ? 16'h7FFF : q[15:0];
        else r = (q > DIV_STEPS'(32768)) ? 16'h8000 : 16'(-q[15:0]);
        return r;
    endfunction

    assign ax[0] = r_item.x;
    assign ax[1] = r_item.y;
    assign o_pop = (r_state == ST_IDLE) && !i_q_empty;
    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            trial[i] = {r_rem[i][14:0], r_num[i][DIV_STEPS-1]};
            res[i]   = finish(ax[i], r_neg[i], r_q[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_tvalid <= 1'b0;
            r_step   <= '0;
        end else begin
            // in ST_HOLD the arm below owns r_tvalid
            if (r_tvalid && i_tready && r_state != ST_HOLD) r_tvalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_item <= i_item;
                        r_step <= '0;
                        r_num[0] <= {mag15(i_item.x.d), 15'd0};
                        r_num[1] <= {mag15(i_item.y.d), 15'd0};
                        r_div[0] <= mag15(i_item.x.span);
                        r_div[1] <= mag15(i_item.y.span);
                        r_neg[0] <= i_item.x.d[15] ^ i_item.x.span[15];
                        r_neg[1] <= i_item.y.d[15] ^ i_item.y.span[15];
                        r_rem[0] <= '0; r_rem[1] <= '0;
                        r_q[0]   <= '0; r_q[1]   <= '0;
                        r_state  <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    for (int i = 0; i < 2; i++) begin
                        r_num[i] <= {r_num[i][DIV_STEPS-2:0], 1'b0};
                        if (trial[i] >= {1'b0, r_div[i]}) begin
                            r_rem[i] <= trial[i] - {1'b0, r_div[i]};
                            r_q[i]   <= {r_q[i][DIV_STEPS-2:0], 1'b1};
                        end else begin
                            r_rem[i] <= trial[i];
                            r_q[i]   <= {r_q[i][DIV_STEPS-2:0], 1'b0};
                        end
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == CW'(DIV_STEPS - 1)) r_state <= ST_HOLD;
                end
                ST_HOLD: begin
                    if (!r_tvalid || i_tready) begin
                        r_tvalid <= 1'b1;
                        r_tdata  <= {5'd0, r_item.done, r_item.is_cal, r_item.pressed,
                                     res[1], res[0]};
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
